### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define WLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/wls_pkg.sv
package wls_pkg;

  // Record store geometry
  localparam int RECORD_DEPTH = 2048;
  localparam int ADDR_W       = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int COUNT_W      = $clog2(RECORD_DEPTH + 1);

  // Field widths
  localparam int MODE_W      = 2;
  localparam int TIME_W      = 48;
  localparam int LAT_W       = 32;
  localparam int LEN_W       = 24;
  localparam int START_W     = 49;
  localparam int WIN_W       = START_W + 1;
  localparam int OUT_COUNT_W = 12;
  localparam int REC_W       = 2 * TIME_W + LAT_W;
  localparam int SUM_W       = LAT_W + COUNT_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(200);

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### hdl/wls_ram.sv
module wls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/wls_div.sv
module wls_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wls_pkg::SUM_W-1:0]    dividend,
  input  logic [wls_pkg::COUNT_W-1:0]  divisor,
  output wls_pkg::div_status_t         status,
  output logic [wls_pkg::SUM_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(wls_pkg::SUM_W + 1);

  logic                          busy;
  logic                          done;
  logic [STEP_W-1:0]             step;
  logic [wls_pkg::COUNT_W:0]     rem;
  logic [wls_pkg::COUNT_W-1:0]   dsr;
  logic [wls_pkg::COUNT_W:0]     rem_sh;
  logic [wls_pkg::COUNT_W:0]     diff;
  logic                          ge;

  // Restoring step: one quotient bit per cycle, dividend shifts out of quotient reg
  always_comb begin
    rem_sh = {rem[wls_pkg::COUNT_W-1:0], quotient[wls_pkg::SUM_W-1]};
    ge     = (rem_sh >= {1'b0, dsr});
    diff   = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= STEP_W'(wls_pkg::SUM_W);
    end else if (busy) begin
      step <= step - STEP_W'(1);
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[wls_pkg::SUM_W-2:0], ge};
      rem      <= ge ? diff : rem_sh;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

### hdl/windowed_latency_stats.sv
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+----------------------------------------
// in       | input     | in_valid / in_stall   | mode, request_time, response_time,
//          |           |                       | latency, window_start
// out      | output    | out_valid / out_stall | request_count, response_count,
//          |           |                       | average_latency, maximum_latency,
//          |           |                       | window_closed, store_full
// cfg      | input     | cfg_we                | cfg_wdata (window_length)
//
// Load, clear and no-op items skip the scan and the divide. A query reads one record
// per cycle through the single read port of the record RAM, two compare stages, then
// a bit-serial divide of SUM_W steps for the average; the divide is skipped when no
// response falls in the window.
// Synchronous active-high reset empties the store and sets the window length to 200;
// RAM contents are not cleared. A new item is taken once the previous result is in the
// output register; out_stall holds that register.
`include "assert_macros.svh"

module windowed_latency_stats (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wls_pkg::MODE_W-1:0]        mode,
  input  logic [wls_pkg::TIME_W-1:0]        request_time,
  input  logic [wls_pkg::TIME_W-1:0]        response_time,
  input  logic [wls_pkg::LAT_W-1:0]         latency,
  input  logic signed [wls_pkg::START_W-1:0] window_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wls_pkg::OUT_COUNT_W-1:0]   request_count,
  output logic [wls_pkg::OUT_COUNT_W-1:0]   response_count,
  output logic [wls_pkg::LAT_W-1:0]         average_latency,
  output logic [wls_pkg::LAT_W-1:0]         maximum_latency,
  output logic                              window_closed,
  output logic                              store_full,
  input  logic                              cfg_we,
  input  logic [wls_pkg::LEN_W-1:0]         cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int CW = wls_pkg::COUNT_W;
  localparam int TW = wls_pkg::TIME_W;
  localparam int LW = wls_pkg::LAT_W;
  localparam int WW = wls_pkg::WIN_W;

  logic [1:0]                   state;
  logic [wls_pkg::LEN_W-1:0]    window_length;
  logic [CW-1:0]                fill;
  logic                         accept;
  logic                         do_load;

  // Query window bounds
  logic signed [WW-1:0]         win_lo;
  logic signed [WW-1:0]         win_hi;

  // Scan pipeline
  logic [CW-1:0]                rd_cnt;
  logic                         issue;
  logic                         p1_valid;
  logic                         p1_last;
  logic                         p2_valid;
  logic                         p2_req;
  logic                         p2_rsp;
  logic                         p2_closed;
  logic [LW-1:0]                p2_lat;
  logic                         scan_end;
  logic [wls_pkg::REC_W-1:0]    rdata;
  logic signed [WW-1:0]         rec_req;
  logic signed [WW-1:0]         rec_rsp;
  logic [LW-1:0]                rec_lat;

  // Accumulators and pending result
  logic [CW-1:0]                req_cnt;
  logic [CW-1:0]                res_cnt;
  logic [wls_pkg::SUM_W-1:0]    lat_sum;
  logic [LW-1:0]                lat_max;
  logic                         closed;
  logic                         full_flag;
  logic [LW-1:0]                avg;

  logic                         div_start;
  wls_pkg::div_status_t         div_status;
  logic [wls_pkg::SUM_W-1:0]    div_quot;
  logic                         out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign do_load  = accept && (mode == wls_pkg::MODE_LOAD) &&
                    (fill < CW'(wls_pkg::RECORD_DEPTH));
  assign issue    = (state == S_SCAN) && (rd_cnt != fill);
  assign scan_end = (state == S_SCAN) && (rd_cnt == fill) && !p1_valid && !p2_valid;
  assign div_start = scan_end && (res_cnt != '0);
  assign out_free = !out_valid || !out_stall;

  // Window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= wls_pkg::LEN_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // Record RAM: {request, response, latency}. Writes only happen while idle,
  // scans only while busy, so no read can overlap a write.
  wls_ram #(
    .WIDTH (wls_pkg::REC_W),
    .DEPTH (wls_pkg::RECORD_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (fill[wls_pkg::ADDR_W-1:0]),
    .wdata ({request_time, response_time, latency}),
    .raddr (rd_cnt[wls_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign rec_req = $signed({2'b00, rdata[wls_pkg::REC_W-1 -: TW]});
  assign rec_rsp = $signed({2'b00, rdata[wls_pkg::REC_W-TW-1 -: TW]});
  assign rec_lat = rdata[LW-1:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (do_load) begin
              fill <= fill + CW'(1);
            end
            if (mode == wls_pkg::MODE_CLEAR) begin
              fill <= '0;
            end
            state <= (mode == wls_pkg::MODE_QUERY) ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= div_start ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Scan pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt   <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      if (accept) begin
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      p1_valid <= issue;
      p2_valid <= p1_valid;
    end
  end

  // Window bounds, hit flags and accumulation
  always_ff @(posedge clk) begin
    p1_last   <= (CW'(rd_cnt + CW'(1)) == fill);
    p2_req    <= (win_lo <= rec_req) && (rec_req < win_hi);
    p2_rsp    <= (win_lo <= rec_rsp) && (rec_rsp < win_hi);
    p2_closed <= p1_last && (rec_rsp >= win_hi);
    p2_lat    <= rec_lat;
    if (accept) begin
      win_lo    <= WW'(window_start);
      win_hi    <= WW'(window_start) + $signed({{(WW-wls_pkg::LEN_W){1'b0}}, window_length});
      req_cnt   <= '0;
      res_cnt   <= '0;
      lat_sum   <= '0;
      lat_max   <= '0;
      closed    <= 1'b0;
      avg       <= '0;
      full_flag <= (mode == wls_pkg::MODE_LOAD) && (fill >= CW'(wls_pkg::RECORD_DEPTH));
    end else begin
      if (p2_valid) begin
        req_cnt <= req_cnt + CW'(p2_req);
        if (p2_rsp) begin
          res_cnt <= res_cnt + CW'(1);
          lat_sum <= lat_sum + wls_pkg::SUM_W'(p2_lat);
          if (p2_lat > lat_max) begin
            lat_max <= p2_lat;
          end
        end
        if (p2_closed) begin
          closed <= 1'b1;
        end
      end
      if (div_status.done) begin
        avg <= div_quot[LW-1:0];
      end
    end
  end

  // Average divider
  wls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lat_sum),
    .divisor  (res_cnt),
    .status   (div_status),
    .quotient (div_quot)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      request_count   <= wls_pkg::OUT_COUNT_W'(req_cnt);
      response_count  <= wls_pkg::OUT_COUNT_W'(res_cnt);
      average_latency <= avg;
      maximum_latency <= lat_max;
      window_closed   <= closed;
      store_full      <= full_flag;
    end
  end

  // Checks
  `WLS_ASSERT_ALWAYS(a_fill_bound, (rst || (fill <= CW'(wls_pkg::RECORD_DEPTH))), "fill count past depth")
  `WLS_ASSERT(a_load_fill, (do_load |=> (fill == CW'($past(fill) + CW'(1)))), "load did not advance fill")
  `WLS_ASSERT(a_scan_pipe, ((p1_valid || p2_valid) |-> (state == S_SCAN)), "scan data outside scan")
  `WLS_ASSERT(a_div_idle, (div_status.busy |-> (state == S_DIV)), "divider busy outside divide")
  `WLS_ASSERT(a_resp_bound, ((state == S_SCAN) |-> (res_cnt <= rd_cnt)), "more responses than records")

endmodule
